// ----- src/crfe_pkg.sv -----
// shared types, sizes and helpers of the clipped rectangle fill engine
// no dependencies; used by clipped_rect_fill_engine
`default_nettype none
package crfe_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration register width and effective frame size widths
    localparam int CFG_W = 10;
    localparam int W_W   = ($clog2(MAX_WIDTH + 1) < CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int H_W   = ($clog2(MAX_HEIGHT + 1) < CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

    // column and row index widths
    localparam int X_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int Y_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int P_W = Y_W + W_W;

    localparam int COORD_W = 16;
    localparam int PIX_W   = 32;

    localparam int RESET_WIDTH  = 320;
    localparam int RESET_HEIGHT = 240;

    localparam logic [0:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'd1;

    typedef enum logic [1:0] {
        MODE_PLOT = 2'd0,
        MODE_FILL = 2'd1,
        MODE_READ = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_FINISH
    } t_state;

    // rgb565 to argb8888 by bit replication, alpha forced to ff
    function automatic logic [PIX_W-1:0] expand565(input logic [15:0] c);
        logic [4:0] r;
        logic [5:0] g;
        logic [4:0] b;
        r = c[15:11];
        g = c[10:5];
        b = c[4:0];
        return {8'hFF, r, r[4:2], g, g[5:4], b, b[4:2]};
    endfunction

endpackage
`default_nettype wire

// ----- src/clipped_rect_fill_engine.sv -----
// Clipped rectangle fill engine: plot, clipped fill and read-back over one pixel memory
// Steps: accept, execute, then for a fill one memory write per pixel inside the frame, then
// finish, where the result is registered. One request at a time: the input stalls from the
// accept until the finish step hands off the result; a stalled result holds the finish step.
// Reset: synchronous; a clearing pass then writes zero to all MAX_WIDTH*MAX_HEIGHT words
// before any request.
`default_nettype none
module clipped_rect_fill_engine (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [0:0]                   i_cfg_index,
    input  wire logic [crfe_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [1:0]                   i_mode,
    input  wire logic [crfe_pkg::COORD_W-1:0] i_x_pos,
    input  wire logic [crfe_pkg::COORD_W-1:0] i_y_pos,
    input  wire logic [crfe_pkg::COORD_W-1:0] i_rect_width,
    input  wire logic [crfe_pkg::COORD_W-1:0] i_rect_height,
    input  wire logic [15:0]                  i_color,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic                              o_status,
    output logic [crfe_pkg::PIX_W-1:0]        o_pixel_data
);

    localparam int AW = crfe_pkg::ADDR_W;
    localparam int XW = crfe_pkg::X_W;
    localparam int YW = crfe_pkg::Y_W;
    localparam int PW = crfe_pkg::P_W;
    localparam int CW = crfe_pkg::COORD_W;

    // configuration
    logic [crfe_pkg::CFG_W-1:0] r_frame_width;
    logic [crfe_pkg::CFG_W-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= crfe_pkg::CFG_W'(crfe_pkg::RESET_WIDTH);
            r_frame_height <= crfe_pkg::CFG_W'(crfe_pkg::RESET_HEIGHT);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                crfe_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                crfe_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [crfe_pkg::W_W-1:0] eff_w;
    logic [crfe_pkg::H_W-1:0] eff_h;

    assign eff_w = (32'(r_frame_width) > 32'(crfe_pkg::MAX_WIDTH))
                 ? crfe_pkg::W_W'(crfe_pkg::MAX_WIDTH) : crfe_pkg::W_W'(r_frame_width);
    assign eff_h = (32'(r_frame_height) > 32'(crfe_pkg::MAX_HEIGHT))
                 ? crfe_pkg::H_W'(crfe_pkg::MAX_HEIGHT) : crfe_pkg::H_W'(r_frame_height);

    // request registers
    crfe_pkg::t_mode r_mode;
    logic [CW-1:0]   r_x;
    logic [CW-1:0]   r_y;
    logic [CW-1:0]   r_w;
    logic [CW-1:0]   r_h;
    logic [15:0]     r_color;

    logic in_accept;
    assign in_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode  <= crfe_pkg::t_mode'(i_mode);
            r_x     <= i_x_pos;
            r_y     <= i_y_pos;
            r_w     <= i_rect_width;
            r_h     <= i_rect_height;
            r_color <= i_color;
        end
    end

    // clipping and address arithmetic
    logic signed [CW:0] x17, y17, x_end, y_end, x_lo, y_lo, x_hi, y_hi, fw17, fh17;
    logic               pix_in_frame;
    logic               fill_neg;
    logic               fill_empty;
    logic [XW-1:0]      mult_x;
    logic [YW-1:0]      mult_y;
    logic [PW-1:0]      prod;
    logic [AW-1:0]      pix_addr;
    logic [PW:0]        pix_sum;
    logic [crfe_pkg::PIX_W-1:0] color_word;

    assign x17   = $signed({r_x[CW-1], r_x});
    assign y17   = $signed({r_y[CW-1], r_y});
    assign fw17  = $signed((CW+1)'(eff_w));
    assign fh17  = $signed((CW+1)'(eff_h));
    assign x_end = x17 + $signed({r_w[CW-1], r_w});
    assign y_end = y17 + $signed({r_h[CW-1], r_h});
    assign x_lo  = r_x[CW-1] ? '0 : x17;
    assign y_lo  = r_y[CW-1] ? '0 : y17;
    assign x_hi  = (x_end > fw17) ? fw17 : x_end;
    assign y_hi  = (y_end > fh17) ? fh17 : y_end;

    assign pix_in_frame = !r_x[CW-1] && !r_y[CW-1] && (x17 < fw17) && (y17 < fh17);
    assign fill_neg     = r_w[CW-1] || r_h[CW-1];
    assign fill_empty   = (x_lo >= x_hi) || (y_lo >= y_hi);

    // one multiplier serves the pixel address and the first row base of a fill
    assign mult_x   = (r_mode == crfe_pkg::MODE_FILL) ? x_lo[XW-1:0] : r_x[XW-1:0];
    assign mult_y   = (r_mode == crfe_pkg::MODE_FILL) ? y_lo[YW-1:0] : r_y[YW-1:0];
    assign prod     = PW'(mult_y) * PW'(eff_w);
    assign pix_sum  = {1'b0, prod} + (PW+1)'(mult_x);
    assign pix_addr = pix_sum[AW-1:0];

    assign color_word = crfe_pkg::expand565(r_color);

    // control
    crfe_pkg::t_state r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [AW-1:0] r_row_base, n_row_base;
    logic [XW-1:0] r_col, n_col, r_col_start, n_col_start, r_col_last, n_col_last;
    logic [YW-1:0] r_row, n_row, r_row_last, n_row_last;
    logic          r_res_status, n_res_status;
    logic          r_res_read, n_res_read;
    logic          r_out_valid, n_out_valid;
    logic          r_status, n_status;
    logic [crfe_pkg::PIX_W-1:0] r_pixel_data, n_pixel_data;
    logic          out_free;

    logic                       mem_we;
    logic                       mem_re;
    logic [AW-1:0]              mem_addr;
    logic [crfe_pkg::PIX_W-1:0] mem_wdata;
    logic [crfe_pkg::PIX_W-1:0] r_mem_q;
    logic signed [CW:0]         x_hi_m1, y_hi_m1;

    assign x_hi_m1  = x_hi - 17'sd1;
    assign y_hi_m1  = y_hi - 17'sd1;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_row_base   = r_row_base;
        n_col        = r_col;
        n_col_start  = r_col_start;
        n_col_last   = r_col_last;
        n_row        = r_row;
        n_row_last   = r_row_last;
        n_res_status = r_res_status;
        n_res_read   = r_res_read;
        n_out_valid  = r_out_valid && i_out_stall;
        n_status     = r_status;
        n_pixel_data = r_pixel_data;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_addr     = pix_addr;
        mem_wdata    = color_word;

        unique case (r_state)
            crfe_pkg::ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_addr   = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(crfe_pkg::DEPTH - 1)) begin
                    n_state = crfe_pkg::ST_IDLE;
                end
            end
            crfe_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = crfe_pkg::ST_EXEC;
                end
            end
            crfe_pkg::ST_EXEC: begin
                n_res_read = 1'b0;
                n_state    = crfe_pkg::ST_FINISH;
                unique case (r_mode)
                    crfe_pkg::MODE_PLOT: begin
                        mem_we       = pix_in_frame;
                        n_res_status = !pix_in_frame;
                    end
                    crfe_pkg::MODE_READ: begin
                        mem_re       = pix_in_frame;
                        n_res_status = !pix_in_frame;
                        n_res_read   = pix_in_frame;
                    end
                    crfe_pkg::MODE_FILL: begin
                        n_res_status = fill_neg;
                        if (!fill_neg && !fill_empty) begin
                            n_state     = crfe_pkg::ST_FILL;
                            n_row_base  = prod[AW-1:0];
                            n_col       = x_lo[XW-1:0];
                            n_col_start = x_lo[XW-1:0];
                            n_col_last  = x_hi_m1[XW-1:0];
                            n_row       = y_lo[YW-1:0];
                            n_row_last  = y_hi_m1[YW-1:0];
                        end
                    end
                    default: begin
                        n_res_status = 1'b1;
                    end
                endcase
            end
            crfe_pkg::ST_FILL: begin
                mem_we   = 1'b1;
                mem_addr = r_row_base + AW'(r_col);
                if (r_col == r_col_last) begin
                    n_col = r_col_start;
                    if (r_row == r_row_last) begin
                        n_state = crfe_pkg::ST_FINISH;
                    end else begin
                        n_row      = r_row + YW'(1);
                        n_row_base = r_row_base + AW'(eff_w);
                    end
                end else begin
                    n_col = r_col + XW'(1);
                end
            end
            crfe_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_status     = r_res_status;
                    n_pixel_data = r_res_read ? r_mem_q : '0;
                    n_state      = crfe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = crfe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= crfe_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row_base   <= n_row_base;
        r_col        <= n_col;
        r_col_start  <= n_col_start;
        r_col_last   <= n_col_last;
        r_row        <= n_row;
        r_row_last   <= n_row_last;
        r_res_status <= n_res_status;
        r_res_read   <= n_res_read;
        r_status     <= n_status;
        r_pixel_data <= n_pixel_data;
    end

    // pixel memory, one port, registered read
    logic [crfe_pkg::PIX_W-1:0] pixel_mem [crfe_pkg::DEPTH];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            pixel_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= pixel_mem[mem_addr];
        end
    end

    assign o_in_stall   = (r_state != crfe_pkg::ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_pixel_data = r_pixel_data;

`ifndef SYNTHESIS
    // fill walk never runs past its clipped corner
    a_fill_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == crfe_pkg::ST_FILL) |-> (r_col <= r_col_last) && (r_row <= r_row_last))
        else $error("fill position beyond clipped rectangle");

    // a result appears only out of the finish step
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == crfe_pkg::ST_FINISH))
        else $error("result raised outside finish step");

    // a pending read result always follows an issued memory read
    a_read_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == crfe_pkg::ST_FINISH) && r_res_read
            |-> $past(mem_re) || ($past(r_state) == crfe_pkg::ST_FINISH))
        else $error("read result without memory read");
`endif

endmodule
`default_nettype wire
